@@ src/hncc_pkg.sv @@
// Shared types and constants for the HSV nearest-center classifier.
// No dependencies; every other file uses it by scoped names.
`default_nettype none

package hncc_pkg;

    localparam int HUE_W     = 8;
    localparam int SAT_W     = 8;
    localparam int VAL_W     = 8;
    localparam int CENTER_W  = HUE_W + SAT_W + VAL_W;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = 3;
    localparam int DIST_W    = 18;
    localparam int DH_W      = 7;
    localparam int SQH_W     = 13;
    localparam int SQ_W      = 16;

    localparam int REG_COUNT  = 6;
    localparam int SLOT_COUNT = 8;

    localparam logic [HUE_W-1:0]  HUE_PERIOD = 8'd180;
    localparam logic [HUE_W-1:0]  HUE_HALF   = 8'd90;
    localparam logic [DIST_W-1:0] MAX_DIST   = 18'd138150;

    // pipeline stages
    localparam int STG_DIFF  = 0;
    localparam int STG_SQR   = 1;
    localparam int STG_SUM   = 2;
    localparam int STG_PAIR  = 3;
    localparam int STG_OUT   = 4;
    localparam int STG_COUNT = 5;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
    } t_center;

    typedef struct packed {
        logic [STG_COUNT-1:0] en;
    } t_stage_ctl;

endpackage

`default_nettype wire

@@ src/hncc_if.sv @@
// Handshake channels of the classifier: sample input, result output, register write.
// Depends on hncc_pkg.
`default_nettype none

interface hncc_in_if;
    logic                       valid;
    logic                       ready;
    logic [hncc_pkg::HUE_W-1:0] hue;
    logic [hncc_pkg::SAT_W-1:0] sat;
    logic [hncc_pkg::VAL_W-1:0] val;

    modport source (output valid, output hue, output sat, output val, input ready);
    modport sink (input valid, input hue, input sat, input val, output ready);
endinterface

interface hncc_out_if;
    logic                        valid;
    logic                        ready;
    logic [hncc_pkg::IDX_W-1:0]  best_index;
    logic [hncc_pkg::DIST_W-1:0] best_dist_sq;

    modport source (output valid, output best_index, output best_dist_sq, input ready);
    modport sink (input valid, input best_index, input best_dist_sq, output ready);
endinterface

interface hncc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hncc_pkg::CFG_IDX_W-1:0] index;
    logic [hncc_pkg::CENTER_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/hncc_center_regs.sv @@
// Reference color registers written through the configuration channel.
// Depends on hncc_pkg and hncc_cfg_if.
`default_nettype none

module hncc_center_regs #(
    parameter int NUM_CENTERS = 6
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    hncc_cfg_if.sink            i_cfg,
    output hncc_pkg::t_center   o_center [NUM_CENTERS]
);

    hncc_pkg::t_center r_center [hncc_pkg::REG_COUNT];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hncc_pkg::REG_COUNT; k++) begin
                r_center[k] <= '0;
            end
        end else if (i_cfg.valid) begin
            for (int k = 0; k < hncc_pkg::REG_COUNT; k++) begin
                if (i_cfg.index == hncc_pkg::CFG_IDX_W'(k)) begin
                    r_center[k] <= i_cfg.data;
                end
            end
        end
    end

    // centers past the register file hold color zero
    for (genvar k = 0; k < NUM_CENTERS; k++) begin : g_out
        if (k < hncc_pkg::REG_COUNT) begin : g_reg
            assign o_center[k] = r_center[k];
        end else begin : g_zero
            assign o_center[k] = '0;
        end
    end

endmodule

`default_nettype wire

@@ src/hncc_dist_lane.sv @@
// Squared HSV distance from the sample to one center: difference, square, sum stages.
// Depends on hncc_pkg.
`default_nettype none

module hncc_dist_lane (
    input  wire                          i_clk,
    input  hncc_pkg::t_stage_ctl         i_ctl,
    input  wire [hncc_pkg::HUE_W-1:0]    i_hue,
    input  wire [hncc_pkg::SAT_W-1:0]    i_sat,
    input  wire [hncc_pkg::VAL_W-1:0]    i_val,
    input  hncc_pkg::t_center            i_center,
    output logic [hncc_pkg::DIST_W-1:0]  o_dist
);

    logic [hncc_pkg::HUE_W-1:0] w_hd;
    logic [hncc_pkg::DH_W-1:0]  n_dh;
    logic [hncc_pkg::SAT_W-1:0] n_ds;
    logic [hncc_pkg::VAL_W-1:0] n_dv;

    logic [hncc_pkg::DH_W-1:0]  r_dh;
    logic [hncc_pkg::SAT_W-1:0] r_ds;
    logic [hncc_pkg::VAL_W-1:0] r_dv;
    logic [hncc_pkg::SQH_W-1:0] r_sq_h;
    logic [hncc_pkg::SQ_W-1:0]  r_sq_s;
    logic [hncc_pkg::SQ_W-1:0]  r_sq_v;
    logic [hncc_pkg::DIST_W-1:0] r_dist;

    // fold the hue difference onto the circle of period 180
    always_comb begin
        w_hd = (i_hue > i_center.hue) ? i_hue - i_center.hue : i_center.hue - i_hue;
        if (w_hd <= hncc_pkg::HUE_HALF) begin
            n_dh = w_hd[hncc_pkg::DH_W-1:0];
        end else if (w_hd <= hncc_pkg::HUE_PERIOD) begin
            n_dh = hncc_pkg::DH_W'(hncc_pkg::HUE_PERIOD - w_hd);
        end else begin
            n_dh = hncc_pkg::DH_W'(w_hd - hncc_pkg::HUE_PERIOD);
        end
        n_ds = (i_sat > i_center.sat) ? i_sat - i_center.sat : i_center.sat - i_sat;
        n_dv = (i_val > i_center.val) ? i_val - i_center.val : i_center.val - i_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[hncc_pkg::STG_DIFF]) begin
            r_dh <= n_dh;
            r_ds <= n_ds;
            r_dv <= n_dv;
        end
        if (i_ctl.en[hncc_pkg::STG_SQR]) begin
            r_sq_h <= hncc_pkg::SQH_W'(r_dh) * hncc_pkg::SQH_W'(r_dh);
            r_sq_s <= hncc_pkg::SQ_W'(r_ds) * hncc_pkg::SQ_W'(r_ds);
            r_sq_v <= hncc_pkg::SQ_W'(r_dv) * hncc_pkg::SQ_W'(r_dv);
        end
        if (i_ctl.en[hncc_pkg::STG_SUM]) begin
            r_dist <= hncc_pkg::DIST_W'(r_sq_h) + hncc_pkg::DIST_W'(r_sq_s)
                    + hncc_pkg::DIST_W'(r_sq_v);
        end
    end

    assign o_dist = r_dist;

endmodule

`default_nettype wire

@@ src/hncc_min_tree.sv @@
// Registered minimum tree over the center distances; lowest index wins ties.
// Depends on hncc_pkg.
`default_nettype none

module hncc_min_tree #(
    parameter int NUM_CENTERS = 6
) (
    input  wire                          i_clk,
    input  hncc_pkg::t_stage_ctl         i_ctl,
    input  wire [hncc_pkg::DIST_W-1:0]   i_dist [NUM_CENTERS],
    output logic [hncc_pkg::IDX_W-1:0]   o_best_index,
    output logic [hncc_pkg::DIST_W-1:0]  o_best_dist
);

    localparam int PAIRS = hncc_pkg::SLOT_COUNT / 2;

    logic [hncc_pkg::DIST_W-1:0] w_pad_d  [hncc_pkg::SLOT_COUNT];
    logic [hncc_pkg::DIST_W-1:0] n_l1_d   [PAIRS];
    logic [hncc_pkg::IDX_W-1:0]  n_l1_i   [PAIRS];
    logic [hncc_pkg::DIST_W-1:0] r_l1_d   [PAIRS];
    logic [hncc_pkg::IDX_W-1:0]  r_l1_i   [PAIRS];
    logic [hncc_pkg::DIST_W-1:0] w_l2_d   [2];
    logic [hncc_pkg::IDX_W-1:0]  w_l2_i   [2];
    logic [hncc_pkg::DIST_W-1:0] n_best_d;
    logic [hncc_pkg::IDX_W-1:0]  n_best_i;
    logic [hncc_pkg::DIST_W-1:0] r_best_d;
    logic [hncc_pkg::IDX_W-1:0]  r_best_i;

    // unused slots sit above any real distance
    for (genvar k = 0; k < hncc_pkg::SLOT_COUNT; k++) begin : g_pad
        if (k < NUM_CENTERS) begin : g_live
            assign w_pad_d[k] = i_dist[k];
        end else begin : g_dead
            assign w_pad_d[k] = '1;
        end
    end

    always_comb begin
        for (int p = 0; p < PAIRS; p++) begin
            if (w_pad_d[2*p+1] < w_pad_d[2*p]) begin
                n_l1_d[p] = w_pad_d[2*p+1];
                n_l1_i[p] = hncc_pkg::IDX_W'(2*p+1);
            end else begin
                n_l1_d[p] = w_pad_d[2*p];
                n_l1_i[p] = hncc_pkg::IDX_W'(2*p);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            if (r_l1_d[2*p+1] < r_l1_d[2*p]) begin
                w_l2_d[p] = r_l1_d[2*p+1];
                w_l2_i[p] = r_l1_i[2*p+1];
            end else begin
                w_l2_d[p] = r_l1_d[2*p];
                w_l2_i[p] = r_l1_i[2*p];
            end
        end
        if (w_l2_d[1] < w_l2_d[0]) begin
            n_best_d = w_l2_d[1];
            n_best_i = w_l2_i[1];
        end else begin
            n_best_d = w_l2_d[0];
            n_best_i = w_l2_i[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[hncc_pkg::STG_PAIR]) begin
            for (int p = 0; p < PAIRS; p++) begin
                r_l1_d[p] <= n_l1_d[p];
                r_l1_i[p] <= n_l1_i[p];
            end
        end
        if (i_ctl.en[hncc_pkg::STG_OUT]) begin
            r_best_d <= n_best_d;
            r_best_i <= n_best_i;
        end
    end

    assign o_best_index = r_best_i;
    assign o_best_dist  = r_best_d;

endmodule

`default_nettype wire

@@ src/hsv_nearest_center_classifier_core.sv @@
// Top level of the HSV nearest-center classifier.
// Depends on hncc_pkg, hncc_if, hncc_center_regs, hncc_dist_lane and hncc_min_tree.
//
// Classifies each HSV sample to the nearest of NUM_CENTERS reference colors
// and returns that center's index with the squared distance (circular hue,
// period 180). Throughput is one sample per clock while the output accepts results;
// each sample passes five register stages: per-center difference, squaring, sum, and
// two levels of the minimum tree. Every stage carries its own valid bit and
// loads whenever it is empty or its successor moves, so bubbles close up and
// input transfers continue into empty stages while a result waits at the output register.
// Center registers may be written only while no sample is in flight.
`default_nettype none

module hsv_nearest_center_classifier_core #(
    parameter int NUM_CENTERS = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    hncc_in_if.sink     i_in,
    hncc_out_if.source  o_out,
    hncc_cfg_if.sink    i_cfg
);

    localparam int LAST = hncc_pkg::STG_COUNT - 1;

    hncc_pkg::t_center          w_center [NUM_CENTERS];
    logic [hncc_pkg::DIST_W-1:0] w_dist  [NUM_CENTERS];
    hncc_pkg::t_stage_ctl       w_ctl;
    logic [hncc_pkg::STG_COUNT-1:0] r_vld;
    logic [hncc_pkg::STG_COUNT-1:0] n_vld;

    always_comb begin
        w_ctl.en[LAST] = !r_vld[LAST] || o_out.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_ctl.en[k] = !r_vld[k] || w_ctl.en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_ctl.en[0]) begin
            n_vld[0] = i_in.valid;
        end
        for (int k = 1; k < hncc_pkg::STG_COUNT; k++) begin
            if (w_ctl.en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_in.ready  = w_ctl.en[0];
    assign o_out.valid = r_vld[LAST];

    hncc_center_regs #(
        .NUM_CENTERS (NUM_CENTERS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_center (w_center)
    );

    for (genvar k = 0; k < NUM_CENTERS; k++) begin : g_lane
        hncc_dist_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_hue    (i_in.hue),
            .i_sat    (i_in.sat),
            .i_val    (i_in.val),
            .i_center (w_center[k]),
            .o_dist   (w_dist[k])
        );
    end

    hncc_min_tree #(
        .NUM_CENTERS (NUM_CENTERS)
    ) u_tree (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_dist       (w_dist),
        .o_best_index (o_out.best_index),
        .o_best_dist  (o_out.best_dist_sq)
    );

    for (genvar k = 0; k < LAST; k++) begin : g_hold_chk
        a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_vld[k] && !w_ctl.en[k]) |=> r_vld[k])
            else $error("stalled stage lost its item");
    end

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ({1'b0, o_out.best_index} < (hncc_pkg::IDX_W + 1)'(NUM_CENTERS)))
        else $error("result index beyond the center count");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.best_dist_sq <= hncc_pkg::MAX_DIST))
        else $error("result distance beyond its bound");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for hsv_nearest_center_classifier_core: directed table, then random phases.
// Depends on hncc_pkg, the hncc_if channel interfaces and the classifier RTL.
`default_nettype none

module tb;

    localparam int NUM_CENTERS  = 6;
    localparam int ACTIVE       = (NUM_CENTERS > hncc_pkg::SLOT_COUNT) ? hncc_pkg::SLOT_COUNT
                                                                       : NUM_CENTERS;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 205;
    localparam int HOLD_AT      = 672;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_ROWS       = 25;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [hncc_pkg::IDX_W-1:0]  idx;
        logic [hncc_pkg::DIST_W-1:0] dsq;
    } t_class_result;

    typedef struct packed {
        t_row_kind                      kind;
        logic [hncc_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [hncc_pkg::CENTER_W-1:0]  word;
        logic                           known;
        logic [hncc_pkg::IDX_W-1:0]     e_idx;
        logic [hncc_pkg::DIST_W-1:0]    e_dist;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    hncc_in_if  in_ch();
    hncc_out_if out_ch();
    hncc_cfg_if cfg_ch();

    hsv_nearest_center_classifier_core #(.NUM_CENTERS(NUM_CENTERS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hncc_pkg::t_center center_regs [hncc_pkg::SLOT_COUNT];
    t_class_result     pending_results [$];
    t_class_result     want;
    t_class_result     typed_result;
    logic              typed_known;
    t_stim_row         directed_rows [N_ROWS];

    bit burst;
    bit hold_req;
    int sent_count;
    int checked_count;
    int cfg_count;
    int error_count;
    int cycles;

    function automatic logic [hncc_pkg::DIST_W-1:0] center_dist(input hncc_pkg::t_center s,
                                                                input hncc_pkg::t_center c);
        logic [hncc_pkg::HUE_W-1:0]  d;
        logic [hncc_pkg::DIST_W-1:0] dh, ds, dv;
        d = (s.hue > c.hue) ? s.hue - c.hue : c.hue - s.hue;
        if (d <= hncc_pkg::HUE_HALF) dh = d;
        else if (d <= hncc_pkg::HUE_PERIOD) dh = hncc_pkg::HUE_PERIOD - d;
        else dh = d - hncc_pkg::HUE_PERIOD;
        ds = (s.sat > c.sat) ? s.sat - c.sat : c.sat - s.sat;
        dv = (s.val > c.val) ? s.val - c.val : c.val - s.val;
        return dh * dh + ds * ds + dv * dv;
    endfunction

    function automatic t_class_result nearest_center(input hncc_pkg::t_center s);
        t_class_result               best;
        logic [hncc_pkg::DIST_W-1:0] d;
        best.idx = '0;
        best.dsq = center_dist(s, center_regs[0]);
        for (int i = 1; i < ACTIVE; i++) begin
            d = center_dist(s, center_regs[i]);
            if (d < best.dsq) begin
                best.dsq = d;
                best.idx = i[hncc_pkg::IDX_W-1:0];
            end
        end
        return best;
    endfunction

    task automatic send_sample(input hncc_pkg::t_center s, input logic known,
                               input t_class_result res);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            @(negedge i_clk) in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid  <= 1'b1;
        in_ch.hue    <= s.hue;
        in_ch.sat    <= s.sat;
        in_ch.val    <= s.val;
        typed_known  <= known;
        typed_result <= res;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic write_center(input logic [hncc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [hncc_pkg::CENTER_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk) cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk) in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (hncc_pkg::STG_COUNT + 3) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // predictor state follows each register transfer
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            cfg_count++;
            if (cfg_ch.index < hncc_pkg::REG_COUNT) center_regs[cfg_ch.index] = cfg_ch.data;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (typed_known) pending_results.push_back(typed_result);
            else pending_results.push_back(nearest_center({in_ch.hue, in_ch.sat, in_ch.val}));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: best_index %0d best_dist_sq %0d",
                       out_ch.best_index, out_ch.best_dist_sq);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (out_ch.best_index !== want.idx) begin
                    $error("best_index: expected %0d, actual %0d", want.idx, out_ch.best_index);
                    error_count++;
                end
                if (out_ch.best_dist_sq !== want.dsq) begin
                    $error("best_dist_sq: expected %0d, actual %0d",
                           want.dsq, out_ch.best_dist_sq);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            if (hold_req) begin
                @(negedge i_clk) out_ch.ready <= 1'b0;
                while (hold_req) @(negedge i_clk);
            end
            stall = burst ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                @(negedge i_clk) out_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // long receiver hold-off so the pipeline fills and backs up the input
    initial begin
        hold_req = 1'b0;
        wait (sent_count >= HOLD_AT);
        @(posedge i_clk) hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_req = 1'b0;
    end

    initial begin
        hncc_pkg::t_center s, c, prev;
        t_class_result     none;
        logic [31:0]       r;
        int                pick;

        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.hue     = '0;
        in_ch.sat     = '0;
        in_ch.val     = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        typed_known   = 1'b0;
        typed_result  = '0;
        none          = '0;
        burst         = 1'b0;
        sent_count    = 0;
        checked_count = 0;
        cfg_count     = 0;
        error_count   = 0;
        cycles        = 0;
        for (int i = 0; i < hncc_pkg::SLOT_COUNT; i++) center_regs[i] = '0;

        directed_rows = '{
            '{ROW_SAMPLE, 3'd0, 24'h000000, 1'b1, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h5AFFFF, 1'b1, 3'd0, 18'd138150},
            '{ROW_SAMPLE, 3'd0, 24'hB30000, 1'b1, 3'd0, 18'd1},
            '{ROW_SAMPLE, 3'd0, 24'hFFFFFF, 1'b1, 3'd0, 18'd135675},
            '{ROW_SAMPLE, 3'd0, 24'hB40000, 1'b1, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h5B0000, 1'b1, 3'd0, 18'd7921},
            '{ROW_CFG,    3'd0, 24'h000000, 1'b0, 3'd0, 18'd0},
            '{ROW_CFG,    3'd1, 24'hB3FFFF, 1'b0, 3'd0, 18'd0},
            '{ROW_CFG,    3'd2, 24'h5A8080, 1'b0, 3'd0, 18'd0},
            '{ROW_CFG,    3'd3, 24'hFF00FF, 1'b0, 3'd0, 18'd0},
            '{ROW_CFG,    3'd4, 24'h000000, 1'b0, 3'd0, 18'd0},
            '{ROW_CFG,    3'd5, 24'h2DC80A, 1'b0, 3'd0, 18'd0},
            '{ROW_CFG,    3'd6, 24'h123456, 1'b0, 3'd0, 18'd0},
            '{ROW_CFG,    3'd7, 24'hFFFFFF, 1'b0, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h000000, 1'b1, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'hB3FFFF, 1'b1, 3'd1, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h5A8080, 1'b1, 3'd2, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'hFF00FF, 1'b1, 3'd3, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h2DC80A, 1'b1, 3'd5, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h00FF00, 1'b0, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h8700FF, 1'b0, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'hC86432, 1'b0, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'hFF0000, 1'b0, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h010101, 1'b0, 3'd0, 18'd0},
            '{ROW_SAMPLE, 3'd0, 24'h644DC8, 1'b0, 3'd0, 18'd0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                wait_idle();
                write_center(directed_rows[k].reg_idx, directed_rows[k].word);
            end else begin
                send_sample(directed_rows[k].word, directed_rows[k].known,
                            '{directed_rows[k].e_idx, directed_rows[k].e_dist});
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            burst = (p == 4);
            prev  = '0;
            for (int k = 0; k < hncc_pkg::REG_COUNT; k++) begin
                if (p == 0) c = '0;
                else if (p == 1) c = '1;
                else begin
                    r = $urandom();
                    case ($urandom_range(0, 3))
                        0: c = r[hncc_pkg::CENTER_W-1:0];
                        1: c = {8'($urandom_range(0, 179)), r[15:8], r[7:0]};
                        2: c = prev;
                        default: begin
                            case (r[1:0])
                                2'd0: c = 24'h000000;
                                2'd1: c = 24'hFFFFFF;
                                2'd2: c = 24'hB3FFFF;
                                default: c = 24'h00FF00;
                            endcase
                        end
                    endcase
                end
                write_center(k[hncc_pkg::CFG_IDX_W-1:0], c);
                prev = c;
            end
            r = $urandom();
            write_center(3'(hncc_pkg::REG_COUNT
                            + $urandom_range(0, hncc_pkg::SLOT_COUNT - hncc_pkg::REG_COUNT - 1)),
                         r[23:0]);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r    = $urandom();
                pick = $urandom_range(0, 9);
                if (pick <= 5) begin
                    s = {8'($urandom_range(0, 179)), r[15:8], r[7:0]};
                end else if (pick <= 7) begin
                    c     = center_regs[$urandom_range(0, hncc_pkg::REG_COUNT - 1)];
                    s.hue = c.hue + 8'($urandom_range(0, 6)) - 8'd3;
                    s.sat = c.sat + 8'($urandom_range(0, 6)) - 8'd3;
                    s.val = c.val + 8'($urandom_range(0, 6)) - 8'd3;
                end else if (pick == 8) begin
                    s = r[hncc_pkg::CENTER_W-1:0];
                end else begin
                    s = center_regs[$urandom_range(0, hncc_pkg::REG_COUNT - 1)];
                end
                send_sample(s, 1'b0, none);
            end
        end
        burst = 1'b0;

        wait_idle();
        repeat (4 * hncc_pkg::STG_COUNT) @(posedge i_clk);

        $display("ran %0d samples through %0d center settings with %0d register writes",
                 sent_count, PHASES + 1, cfg_count);
        $display("checked %0d results, including a %0d-cycle output hold-off",
                 checked_count, HOLD_CYCLES);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
src/hncc_pkg.sv
src/hncc_if.sv
src/hncc_center_regs.sv
src/hncc_dist_lane.sv
src/hncc_min_tree.sv
src/hsv_nearest_center_classifier_core.sv
bench/tb.sv
